>>> src/stft_pkg.sv
// Shared types and constants for the sparse triplet fast transpose block.
package stft_pkg;

    // Field widths fixed by the item format
    localparam int IDX_W   = 8;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 9;
    localparam int DATA_W  = 48;
    localparam int ERR_W   = 2;

    // Configuration register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Error codes carried on every result of a matrix
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_CAP   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INC,
        S_FIN,
        S_ERR_OUT,
        S_PFX,
        S_SC_A,
        S_SC_B,
        S_SC_C,
        S_EM_RD,
        S_EM_LD
    } t_state;

endpackage

>>> src/sparse_triplet_fast_transpose.sv
// Sparse matrix fast transpose over (row, column, value) triplets.
//
// Input stream: one triplet per transaction; tuser = 1 when the transaction
// carries a triplet, tlast closes the matrix. Output stream: transposed
// triplets ordered by new row (source column), stable within a row; tlast on
// the final one, tuser carries the matrix error code on every result.
// Load: a count memory read-modify-write per stored triplet. After the last
// transaction: a prefix sum (one count memory read per column), a scatter
// with a term read, a start read and a start write per stored term, then
// each result is read from the result memory into the output register.
// The input is not ready from the last transaction until the final result
// is loaded into the output register; a stalled receiver holds the sequencer
// at the next result read. An empty matrix with an error gives one zero
// result. Reset clears control state and sets both dimension registers to
// 256; count memory entries are marked invalid at once by a valid bit vector,
// so no clearing pass is needed.
module sparse_triplet_fast_transpose #(
    parameter int MAX_TERMS = 64,
    parameter int MAX_DIM   = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [stft_pkg::CFG_W-1:0]  i_cfg_data,
    // input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [stft_pkg::DATA_W-1:0] i_s_tdata,  // in_row, in_col, in_value
    input  logic                        i_s_tuser,  // carries_entry
    input  logic                        i_s_tlast,  // in_last
    // output stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [stft_pkg::DATA_W-1:0] o_m_tdata,  // out_row, out_col, out_value
    output logic [stft_pkg::ERR_W-1:0]  o_m_tuser,  // out_error
    output logic                        o_m_tlast   // out_last
);

    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int TW = $clog2(MAX_TERMS + 1);
    localparam int AW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int XW = stft_pkg::IDX_W;

    // Memories
    logic [stft_pkg::DATA_W-1:0] r_term_mem  [MAX_TERMS];
    logic [stft_pkg::DATA_W-1:0] r_out_mem   [MAX_TERMS];
    logic [TW-1:0]               r_cnt_mem   [MAX_DIM];
    logic [TW-1:0]               r_start_mem [MAX_DIM];

    logic [stft_pkg::DATA_W-1:0] r_term_rd;
    logic [stft_pkg::DATA_W-1:0] r_out_rd;
    logic [TW-1:0]               r_cnt_rd;
    logic [TW-1:0]               r_start_rd;

    // Control registers
    stft_pkg::t_state            r_state, n_state;
    logic [stft_pkg::CFG_W-1:0]  r_rows, r_cols;
    logic [TW-1:0]               r_tc, n_tc;
    logic [stft_pkg::ERR_W-1:0]  r_err, n_err;
    logic                        r_last, n_last;
    logic [AW-1:0]               r_cur_col, n_cur_col;
    logic [MAX_DIM-1:0]          r_cnt_vld, n_cnt_vld;
    logic [DW-1:0]               r_pf_c, n_pf_c;
    logic [AW-1:0]               r_pf_wc, n_pf_wc;
    logic                        r_pf_wv, n_pf_wv;
    logic [TW-1:0]               r_sum, n_sum;
    logic [TW-1:0]               r_p, n_p;
    logic [TW-1:0]               r_e, n_e;
    logic                        r_o_valid, n_o_valid;
    logic [stft_pkg::DATA_W-1:0] r_o_data, n_o_data;
    logic                        r_o_last, n_o_last;
    logic [stft_pkg::ERR_W-1:0]  r_o_err, n_o_err;

    // Memory controls
    logic                        term_we, term_re;
    logic                        cnt_we, cnt_re;
    logic [AW-1:0]               cnt_waddr, cnt_raddr;
    logic [TW-1:0]               cnt_wdata;
    logic                        st_we, st_re;
    logic [AW-1:0]               st_waddr;
    logic [TW-1:0]               st_wdata;
    logic                        out_we, out_re;

    // Input fields
    logic [XW-1:0]               w_in_row, w_in_col;
    logic [stft_pkg::VAL_W-1:0]  w_in_val;
    logic                        w_acc;
    logic [DW-1:0]               w_ncols, w_nrows;
    logic                        w_range_bad, w_cap_bad, w_ent_ok;

    // Scatter / emission helpers
    logic [XW-1:0]               w_sc, w_trow;
    logic [stft_pkg::VAL_W-1:0]  w_tval;
    logic                        w_sc_in, w_q_ok, w_p_end, w_e_last;
    logic                        w_pf_more, w_pf_done, w_out_free;
    logic [TW-1:0]               w_cnt_cur;

    // Clamp the dimension registers to 1..MAX_DIM
    always_comb begin
        if (r_cols == '0) begin
            w_ncols = DW'(1);
        end else if (32'(r_cols) > 32'(MAX_DIM)) begin
            w_ncols = DW'(MAX_DIM);
        end else begin
            w_ncols = DW'(r_cols);
        end
        if (r_rows == '0) begin
            w_nrows = DW'(1);
        end else if (32'(r_rows) > 32'(MAX_DIM)) begin
            w_nrows = DW'(MAX_DIM);
        end else begin
            w_nrows = DW'(r_rows);
        end
    end

    assign w_in_row = i_s_tdata[7:0];
    assign w_in_col = i_s_tdata[15:8];
    assign w_in_val = i_s_tdata[47:16];
    assign w_acc    = i_s_tvalid && o_s_tready;

    // Entry admission: range check first, then capacity
    assign w_range_bad = i_s_tuser && ((32'(w_in_col) >= 32'(w_ncols)) ||
                                       (32'(w_in_row) >= 32'(w_nrows)));
    assign w_cap_bad   = i_s_tuser && !w_range_bad && (r_tc >= TW'(MAX_TERMS));
    assign w_ent_ok    = i_s_tuser && !w_range_bad && !w_cap_bad;

    // Stored term layout: {value, col, row}
    assign w_trow   = r_term_rd[7:0];
    assign w_sc     = r_term_rd[15:8];
    assign w_tval   = r_term_rd[47:16];
    assign w_sc_in  = 32'(w_sc) < 32'(w_ncols);
    assign w_q_ok   = r_start_rd < r_tc;
    assign w_p_end  = (TW'(r_p + 1'b1) == r_tc);
    assign w_e_last = (TW'(r_e + 1'b1) == r_tc);

    assign w_pf_more  = r_pf_c < w_ncols;
    assign w_pf_done  = !w_pf_more && !r_pf_wv;
    assign w_out_free = !r_o_valid || i_m_tready;

    // Count read data is only meaningful for entries touched in this matrix
    assign w_cnt_cur = r_cnt_vld[(r_state == stft_pkg::S_INC) ? r_cur_col : r_pf_wc]
                       ? r_cnt_rd : '0;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            stft_pkg::S_IDLE: begin
                if (w_acc) begin
                    if (w_ent_ok) begin
                        n_state = stft_pkg::S_INC;
                    end else if (i_s_tlast) begin
                        n_state = stft_pkg::S_FIN;
                    end
                end
            end
            stft_pkg::S_INC: begin
                n_state = r_last ? stft_pkg::S_FIN : stft_pkg::S_IDLE;
            end
            stft_pkg::S_FIN: begin
                if (r_tc != '0) begin
                    n_state = stft_pkg::S_PFX;
                end else if (r_err != stft_pkg::ERR_NONE) begin
                    n_state = stft_pkg::S_ERR_OUT;
                end else begin
                    n_state = stft_pkg::S_IDLE;
                end
            end
            stft_pkg::S_ERR_OUT: begin
                if (w_out_free) n_state = stft_pkg::S_IDLE;
            end
            stft_pkg::S_PFX: begin
                if (w_pf_done) n_state = stft_pkg::S_SC_A;
            end
            stft_pkg::S_SC_A: begin
                n_state = stft_pkg::S_SC_B;
            end
            stft_pkg::S_SC_B: begin
                if (w_sc_in) begin
                    n_state = stft_pkg::S_SC_C;
                end else begin
                    n_state = w_p_end ? stft_pkg::S_EM_RD : stft_pkg::S_SC_A;
                end
            end
            stft_pkg::S_SC_C: begin
                n_state = w_p_end ? stft_pkg::S_EM_RD : stft_pkg::S_SC_A;
            end
            stft_pkg::S_EM_RD: begin
                if (w_out_free) n_state = stft_pkg::S_EM_LD;
            end
            stft_pkg::S_EM_LD: begin
                n_state = w_e_last ? stft_pkg::S_IDLE : stft_pkg::S_EM_RD;
            end
            default: n_state = stft_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_tc      = r_tc;
        n_err     = r_err;
        n_last    = r_last;
        n_cur_col = r_cur_col;
        n_cnt_vld = r_cnt_vld;
        n_pf_c    = r_pf_c;
        n_pf_wc   = r_pf_wc;
        n_pf_wv   = r_pf_wv;
        n_sum     = r_sum;
        n_p       = r_p;
        n_e       = r_e;
        n_o_valid = r_o_valid && !i_m_tready;
        n_o_data  = r_o_data;
        n_o_last  = r_o_last;
        n_o_err   = r_o_err;

        term_we   = 1'b0;
        term_re   = 1'b0;
        cnt_we    = 1'b0;
        cnt_re    = 1'b0;
        cnt_waddr = r_cur_col;
        cnt_raddr = AW'(w_in_col);
        cnt_wdata = TW'(w_cnt_cur + 1'b1);
        st_we     = 1'b0;
        st_re     = 1'b0;
        st_waddr  = r_pf_wc;
        st_wdata  = r_sum;
        out_we    = 1'b0;
        out_re    = 1'b0;

        case (r_state)
            stft_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_last = i_s_tlast;
                    if (r_err == stft_pkg::ERR_NONE) begin
                        if (w_range_bad) n_err = stft_pkg::ERR_RANGE;
                        else if (w_cap_bad) n_err = stft_pkg::ERR_CAP;
                    end
                    if (w_ent_ok) begin
                        term_we   = 1'b1;
                        cnt_re    = 1'b1;
                        n_cur_col = AW'(w_in_col);
                        n_tc      = TW'(r_tc + 1'b1);
                    end
                end
            end
            stft_pkg::S_INC: begin
                cnt_we               = 1'b1;
                n_cnt_vld[r_cur_col] = 1'b1;
            end
            stft_pkg::S_FIN: begin
                n_pf_c  = '0;
                n_pf_wv = 1'b0;
                n_sum   = '0;
                n_p     = '0;
                n_e     = '0;
                if (r_tc == '0 && r_err == stft_pkg::ERR_NONE) begin
                    n_cnt_vld = '0;
                end
            end
            stft_pkg::S_ERR_OUT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_data  = '0;
                    n_o_last  = 1'b1;
                    n_o_err   = r_err;
                    n_tc      = '0;
                    n_err     = stft_pkg::ERR_NONE;
                    n_cnt_vld = '0;
                end
            end
            stft_pkg::S_PFX: begin
                // write start of the column read last cycle, read the next one
                if (r_pf_wv) begin
                    st_we = 1'b1;
                    n_sum = TW'(r_sum + w_cnt_cur);
                end
                if (w_pf_more) begin
                    cnt_re    = 1'b1;
                    cnt_raddr = r_pf_c[AW-1:0];
                    n_pf_wc   = r_pf_c[AW-1:0];
                    n_pf_wv   = 1'b1;
                    n_pf_c    = DW'(r_pf_c + 1'b1);
                end else begin
                    n_pf_wv = 1'b0;
                end
            end
            stft_pkg::S_SC_A: begin
                term_re = 1'b1;
            end
            stft_pkg::S_SC_B: begin
                if (w_sc_in) begin
                    st_re = 1'b1;
                end else begin
                    n_p = TW'(r_p + 1'b1);
                end
            end
            stft_pkg::S_SC_C: begin
                st_we    = 1'b1;
                st_waddr = AW'(w_sc);
                st_wdata = TW'(r_start_rd + 1'b1);
                out_we   = w_q_ok;
                n_p      = TW'(r_p + 1'b1);
            end
            stft_pkg::S_EM_RD: begin
                out_re = w_out_free;
            end
            stft_pkg::S_EM_LD: begin
                n_o_valid = 1'b1;
                n_o_data  = r_out_rd;
                n_o_last  = w_e_last;
                n_o_err   = r_err;
                n_e       = TW'(r_e + 1'b1);
                if (w_e_last) begin
                    n_tc      = '0;
                    n_err     = stft_pkg::ERR_NONE;
                    n_cnt_vld = '0;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= stft_pkg::S_IDLE;
            r_rows    <= stft_pkg::CFG_W'(256);
            r_cols    <= stft_pkg::CFG_W'(256);
            r_tc      <= '0;
            r_err     <= stft_pkg::ERR_NONE;
            r_last    <= 1'b0;
            r_cnt_vld <= '0;
            r_pf_c    <= '0;
            r_pf_wv   <= 1'b0;
            r_sum     <= '0;
            r_p       <= '0;
            r_e       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tc      <= n_tc;
            r_err     <= n_err;
            r_last    <= n_last;
            r_cnt_vld <= n_cnt_vld;
            r_pf_c    <= n_pf_c;
            r_pf_wv   <= n_pf_wv;
            r_sum     <= n_sum;
            r_p       <= n_p;
            r_e       <= n_e;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == stft_pkg::REG_ROWS) r_rows <= i_cfg_data;
                if (i_cfg_idx == stft_pkg::REG_COLS) r_cols <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur_col <= n_cur_col;
        r_pf_wc   <= n_pf_wc;
        r_o_data  <= n_o_data;
        r_o_last  <= n_o_last;
        r_o_err   <= n_o_err;
    end

    // Term memory: {value, col, row}
    always_ff @(posedge i_clk) begin
        if (term_we) r_term_mem[r_tc[IW-1:0]] <= {w_in_val, w_in_col, w_in_row};
        if (term_re) r_term_rd <= r_term_mem[r_p[IW-1:0]];
    end

    // Column count memory
    always_ff @(posedge i_clk) begin
        if (cnt_we) r_cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re) r_cnt_rd <= r_cnt_mem[cnt_raddr];
    end

    // Column start memory
    always_ff @(posedge i_clk) begin
        if (st_we) r_start_mem[st_waddr] <= st_wdata;
        if (st_re) r_start_rd <= r_start_mem[AW'(w_sc)];
    end

    // Transposed result memory, in output order: {value, out_col, out_row}
    always_ff @(posedge i_clk) begin
        if (out_we) r_out_mem[r_start_rd[IW-1:0]] <= {w_tval, w_trow, w_sc};
        if (out_re) r_out_rd <= r_out_mem[r_e[IW-1:0]];
    end

    assign o_s_tready = (r_state == stft_pkg::S_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_err;
    assign o_m_tlast  = r_o_last;

    // Stored term count never passes capacity
    a_tc_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tc <= TW'(MAX_TERMS))
        else $error("term count above capacity");

    // Emission only reads positions that were filled
    a_emit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stft_pkg::S_EM_LD) |-> (r_e < r_tc))
        else $error("emission index past term count");

    // A pending result is never overwritten: sequencer waits on a stall
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stft_pkg::S_EM_RD && r_o_valid && !i_m_tready)
        |=> (r_state == stft_pkg::S_EM_RD))
        else $error("result read issued while output stalled");

endmodule
